/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

/* hw/rtl/aes_rtu_pkg.sv */
// Package with the AES operation codes, S-box tables and GF(2^8) helpers.
`timescale 1ns / 1ps
package aes_rtu_pkg;

  typedef enum logic [2:0] {
    OP_ADD_KEY   = 3'd0,
    OP_SUB       = 3'd1,
    OP_SHIFT     = 3'd2,
    OP_MIX       = 3'd3,
    OP_INV_SUB   = 3'd4,
    OP_INV_SHIFT = 3'd5,
    OP_INV_MIX   = 3'd6,
    OP_WRITE_KEY = 3'd7
  } op_e;

  typedef logic [7:0] state_t [16];

  localparam logic [7:0] GfPoly = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

endpackage

/* hw/rtl/aes_rtu_key_store.sv */
// Round key schedule memory with one write port and one registered row read.
`timescale 1ns / 1ps
module aes_rtu_key_store #(
  parameter int KEY_WORDS = 60
) (
  input  logic         clk_i,
  input  logic         wr_en_i,
  input  logic [5:0]   wr_idx_i,
  input  logic [31:0]  wr_data_i,
  input  logic [3:0]   rd_round_i,
  output logic [127:0] rd_key_o
);
  localparam int Rows = (KEY_WORDS + 3) / 4;

  // Four word banks, one per column, so all four words of a round are read together.
  logic [31:0] mem_q [4][Rows];
  logic [3:0]  rd_valid_q;
  logic [31:0] rd_word_q [4];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (int'(wr_idx_i) < KEY_WORDS)) begin
      mem_q[wr_idx_i[1:0]][wr_idx_i[5:2]] <= wr_data_i;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    always_ff @(posedge clk_i) begin
      rd_valid_q[c] <= (int'(rd_round_i) * 4 + c) < KEY_WORDS;
      rd_word_q[c]  <= mem_q[c][rd_round_i];
    end
    assign rd_key_o[127-32*c -: 32] = rd_valid_q[c] ? rd_word_q[c] : 32'h0;
  end
endmodule

/* hw/rtl/aes_rtu_datapath.sv */
// Combinational transform logic for one registered AES state.
`timescale 1ns / 1ps
module aes_rtu_datapath (
  input  aes_rtu_pkg::op_e op_i,
  input  logic [127:0]     state_i,
  input  logic [127:0]     key_i,
  output logic [127:0]     result_o
);
  aes_rtu_pkg::state_t s, t;

  always_comb begin
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    {a0, a1, a2, a3, x0, x1, x2, x3} = '0;
    {y0, y1, y2, y3, z0, z1, z2, z3} = '0;
    for (int k = 0; k < 16; k++) s[k] = state_i[127-8*k -: 8];
    t = s;
    case (op_i)
      aes_rtu_pkg::OP_ADD_KEY: begin
        for (int k = 0; k < 16; k++) t[k] = s[k] ^ key_i[127-8*k -: 8];
      end
      aes_rtu_pkg::OP_SUB: begin
        for (int k = 0; k < 16; k++) t[k] = aes_rtu_pkg::sbox(s[k]);
      end
      aes_rtu_pkg::OP_INV_SUB: begin
        for (int k = 0; k < 16; k++) t[k] = aes_rtu_pkg::inv_sbox(s[k]);
      end
      aes_rtu_pkg::OP_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c+r)%4)+r];
      end
      aes_rtu_pkg::OP_INV_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c-r+4)%4)+r];
      end
      aes_rtu_pkg::OP_MIX, aes_rtu_pkg::OP_INV_MIX: begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          x0 = aes_rtu_pkg::xtime(a0); x1 = aes_rtu_pkg::xtime(a1);
          x2 = aes_rtu_pkg::xtime(a2); x3 = aes_rtu_pkg::xtime(a3);
          y0 = aes_rtu_pkg::xtime(x0); y1 = aes_rtu_pkg::xtime(x1);
          y2 = aes_rtu_pkg::xtime(x2); y3 = aes_rtu_pkg::xtime(x3);
          z0 = aes_rtu_pkg::xtime(y0); z1 = aes_rtu_pkg::xtime(y1);
          z2 = aes_rtu_pkg::xtime(y2); z3 = aes_rtu_pkg::xtime(y3);
          if (op_i == aes_rtu_pkg::OP_MIX) begin
            t[4*c]   = x0 ^ (x1 ^ a1) ^ a2 ^ a3;
            t[4*c+1] = a0 ^ x1 ^ (x2 ^ a2) ^ a3;
            t[4*c+2] = a0 ^ a1 ^ x2 ^ (x3 ^ a3);
            t[4*c+3] = (x0 ^ a0) ^ a1 ^ a2 ^ x3;
          end else begin
            // 0e = 8+4+2, 0b = 8+2+1, 0d = 8+4+1, 09 = 8+1.
            t[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
            t[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
            t[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
            t[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
          end
        end
      end
      default: t = s;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 16; k++) result_o[127-8*k -: 8] = t[k];
  end
endmodule

/* hw/rtl/aes_round_transform_unit.sv */
// Top level of the AES round transform unit.
//
//  Channel   Direction  Payload
//  s_axis    in         operation, state, round, key word index and value
//  m_axis    out        transformed state (result_upper, result_lower)
//
// A request passes through one input stage (which also reads the key row)
// and one result register. One request is taken per cycle when not stalled;
// a write-key request updates the schedule and produces no result. Reset
// clears only the valid flags; key words are undefined until written. A
// stalled result register stops the input stage, which in turn drops
// s_axis_tready only when both stages are full.
`timescale 1ns / 1ps
module aes_round_transform_unit #(
  parameter int KEY_WORDS = 60
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: operation[2:0], state_upper[66:3], state_lower[130:67],
  // round_number[134:131], key_word_index[140:135], key_word_value[172:141].
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: result_upper[63:0], result_lower[127:64].
  output logic [127:0] m_axis_tdata
);
  logic             in_valid_q;
  aes_rtu_pkg::op_e in_op_q;
  logic [127:0]     in_state_q;
  logic [3:0]       in_round_q;
  logic [127:0]     key_row;
  logic [127:0]     result;
  logic             out_valid_q;
  logic [127:0]     out_data_q;
  logic             out_free, in_adv, s_take;

  assign out_free = !out_valid_q || m_axis_tready;
  // The input stage moves on unless it holds a result the output cannot take.
  assign in_adv = !in_valid_q || out_free;
  assign s_axis_tready = in_adv;
  assign s_take = s_axis_tvalid && in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= s_take &&
            (aes_rtu_pkg::op_e'(s_axis_tdata[2:0]) != aes_rtu_pkg::OP_WRITE_KEY);
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      in_op_q    <= aes_rtu_pkg::op_e'(s_axis_tdata[2:0]);
      in_state_q <= {s_axis_tdata[66:3], s_axis_tdata[130:67]};
    end
    if (out_free && in_valid_q) begin
      out_data_q <= result;
    end
  end

  // The key row is read when the request enters and held while stalled.
  aes_rtu_key_store #(.KEY_WORDS(KEY_WORDS)) u_keys (
    .clk_i      (clk_i),
    .wr_en_i    (s_take &&
                 (aes_rtu_pkg::op_e'(s_axis_tdata[2:0]) == aes_rtu_pkg::OP_WRITE_KEY)),
    .wr_idx_i   (s_axis_tdata[140:135]),
    .wr_data_i  (s_axis_tdata[172:141]),
    .rd_round_i (in_adv ? s_axis_tdata[134:131] : in_round_q),
    .rd_key_o   (key_row)
  );

  always_ff @(posedge clk_i) begin
    if (in_adv) in_round_q <= s_axis_tdata[134:131];
  end

  aes_rtu_datapath u_dp (
    .op_i     (in_op_q),
    .state_i  (in_state_q),
    .key_i    (key_row),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q[63:0], out_data_q[127:64]};
endmodule

/* hw/rtl/aes_rtu_checker.sv */
// Port-level checker for the AES round transform unit, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_rtu_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPL(a_ready_when_out_free, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `ASSERT_IMPL(a_no_spurious_out, clk_i, rst_ni,
    !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
  `ASSERT_IMPL(a_stall_backpressure, clk_i, rst_ni,
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
endmodule

bind aes_round_transform_unit aes_rtu_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* tb/tb_top.sv */
// Self-checking testbench for the AES round transform unit.
`timescale 1ns / 1ps
module tb_top;

  localparam int KeyWords = 60;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // Fields from bit 0: operation, state_upper, state_lower, round_number,
  // key_word_index, key_word_value, then zero fill.
  logic [175:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // Fields from bit 0: result_upper, result_lower.
  logic [127:0] m_axis_tdata;

  aes_round_transform_unit #(.KEY_WORDS(KeyWords)) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Model state: the key schedule, which words have been loaded, S-boxes and expected results.
  logic [31:0]  round_keys [KeyWords];
  bit           key_loaded [KeyWords];
  logic [7:0]   fwd_box [256];
  logic [7:0]   inv_box [256];
  logic [127:0] pending_states [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int err_count;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) begin
        acc ^= a;
      end
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // The S-box is the affine map of the multiplicative inverse in GF(2^8).
  task automatic build_boxes();
    logic [7:0] recip;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      recip = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) begin
          recip = 8'(y);
        end
      end
      s = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]}
          ^ {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ 8'h63;
      fwd_box[x] = s;
      inv_box[s] = 8'(x);
    end
  endtask

  // Applies one transform and returns {result_lower, result_upper}.
  function automatic logic [127:0] transform_state(aes_rtu_pkg::op_e op, logic [63:0] up,
                                                   logic [63:0] lo, logic [3:0] rnd);
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [7:0]  fwd_row [4];
    logic [7:0]  inv_row [4];
    logic [31:0] w;
    logic [63:0] ru;
    logic [63:0] rl;
    int          pos;
    fwd_row = '{8'h02, 8'h03, 8'h01, 8'h01};
    inv_row = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    for (int k = 0; k < 8; k++) begin
      s[k]     = up[63 - 8 * k -: 8];
      s[k + 8] = lo[63 - 8 * k -: 8];
    end
    t = s;
    for (int c = 0; c < 4; c++) begin
      pos = 4 * rnd + c;
      w   = (pos < KeyWords) ? round_keys[pos] : 32'h0;
      for (int r = 0; r < 4; r++) begin
        case (op)
          aes_rtu_pkg::OP_ADD_KEY:   t[4 * c + r] = s[4 * c + r] ^ w[31 - 8 * r -: 8];
          aes_rtu_pkg::OP_SUB:       t[4 * c + r] = fwd_box[s[4 * c + r]];
          aes_rtu_pkg::OP_INV_SUB:   t[4 * c + r] = inv_box[s[4 * c + r]];
          aes_rtu_pkg::OP_SHIFT:     t[4 * c + r] = s[4 * ((c + r) & 3) + r];
          aes_rtu_pkg::OP_INV_SHIFT: t[4 * c + r] = s[4 * ((c - r + 4) & 3) + r];
          default: begin
            t[4 * c + r] = 8'h00;
            for (int k = 0; k < 4; k++) begin
              t[4 * c + r] ^= gf_mul(op == aes_rtu_pkg::OP_MIX ? fwd_row[(k - r) & 3]
                                                               : inv_row[(k - r) & 3],
                                     s[4 * c + k]);
            end
          end
        endcase
      end
    end
    for (int k = 0; k < 8; k++) begin
      ru[63 - 8 * k -: 8] = t[k];
      rl[63 - 8 * k -: 8] = t[k + 8];
    end
    return {rl, ru};
  endfunction

  // Sends one request, keeping tvalid high across back-to-back requests.
  task automatic send_request(aes_rtu_pkg::op_e op, logic [63:0] up, logic [63:0] lo,
                              logic [3:0] rnd, logic [5:0] idx, logic [31:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, val, idx, rnd, lo, up, op};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    if (op == aes_rtu_pkg::OP_WRITE_KEY) begin
      if (idx < KeyWords) begin
        round_keys[idx] = val;
        key_loaded[idx] = 1'b1;
      end
    end else begin
      pending_states.push_back(transform_state(op, up, lo, rnd));
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // True when every schedule word that the round reads has been loaded.
  function automatic bit round_ready(int rnd);
    for (int c = 0; c < 4; c++) begin
      if (4 * rnd + c < KeyWords && !key_loaded[4 * rnd + c]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic wait_drained();
    while (pending_states.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Extremes of the state for every transform, plus the key special cases:
  // writes past the schedule are dropped and rounds past it add zero.
  task automatic test_directed();
    logic [63:0] pat [3];
    pat = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0011_2233_4455_6677};
    for (int c = 0; c < 4; c++) begin
      send_request(aes_rtu_pkg::OP_WRITE_KEY, '0, '0, '0, 6'(c), 32'hffff_ffff);
      send_request(aes_rtu_pkg::OP_WRITE_KEY, '0, '0, '0, 6'(56 + c), 32'h0f1e_2d3c + c);
    end
    send_request(aes_rtu_pkg::OP_WRITE_KEY, '0, '0, '0, 6'd60, 32'h1234_5678);
    send_request(aes_rtu_pkg::OP_WRITE_KEY, '0, '0, '0, 6'd63, 32'hdead_beef);
    send_request(aes_rtu_pkg::OP_ADD_KEY, pat[2], pat[1], 4'd0, 6'd63, 32'hffff_ffff);
    send_request(aes_rtu_pkg::OP_ADD_KEY, pat[1], pat[0], 4'd14, '0, '0);
    send_request(aes_rtu_pkg::OP_ADD_KEY, pat[1], pat[2], 4'd15, '0, '0);
    for (int op = aes_rtu_pkg::OP_SUB; op <= aes_rtu_pkg::OP_INV_MIX; op++) begin
      send_request(aes_rtu_pkg::op_e'(op), pat[op % 3], pat[(op + 1) % 3], 4'hf, 6'h3f,
                   '1);
    end
    send_request(aes_rtu_pkg::OP_MIX, 64'hdb13_5345_f20a_225c, 64'h0101_0101_c6c6_c6c6,
                 '0, '0, '0);
    stop_sending();
  endtask

  // Loads the whole schedule in a random order.
  task automatic test_key_load();
    int order [KeyWords];
    int j;
    int tmp;
    for (int i = 0; i < KeyWords; i++) begin
      order[i] = i;
    end
    for (int i = KeyWords - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < KeyWords; i++) begin
      send_request(aes_rtu_pkg::OP_WRITE_KEY, {$urandom, $urandom}, {$urandom, $urandom},
                   4'($urandom), 6'(order[i]), $urandom);
    end
  endtask

  task automatic send_random_request();
    aes_rtu_pkg::op_e op;
    logic [3:0]       rnd;
    op  = aes_rtu_pkg::op_e'($urandom_range(7));
    rnd = 4'($urandom_range(15));
    if (op == aes_rtu_pkg::OP_ADD_KEY && !round_ready(rnd)) begin
      rnd = 4'd15;
    end
    send_request(op, {$urandom, $urandom}, {$urandom, $urandom}, rnd,
                 6'($urandom_range(63)), $urandom);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      send_random_request();
    end
    stop_sending();
  endtask

  // The receiver holds off while requests keep coming, so both stages fill
  // and the input stalls; afterwards the sender waits for the pipe to empty.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    for (int i = 0; i < 40; i++) begin
      send_random_request();
    end
    stop_sending();
    wait_drained();
  endtask

  // Result checker and receiver ready; outputs are sampled before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_states.size() == 0) begin
        $error("result_upper: expected none, actual %h", m_axis_tdata[63:0]);
        err_count++;
      end else begin
        if (m_axis_tdata[63:0] !== pending_states[0][63:0]) begin
          $error("result_upper: expected %h, actual %h",
                 pending_states[0][63:0], m_axis_tdata[63:0]);
          err_count++;
        end
        if (m_axis_tdata[127:64] !== pending_states[0][127:64]) begin
          $error("result_lower: expected %h, actual %h",
                 pending_states[0][127:64], m_axis_tdata[127:64]);
          err_count++;
        end
        void'(pending_states.pop_front());
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    err_count      = 0;
    for (int i = 0; i < KeyWords; i++) begin
      round_keys[i] = '0;
      key_loaded[i] = 1'b0;
    end
    build_boxes();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_key_load();
    test_random(325, 0, 0);
    test_backpressure();
    test_random(325, 86, 0);
    test_random(325, 0, 86);
    test_random(325, 37, 37);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending_states.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/aes_rtu_pkg.sv
hw/rtl/aes_rtu_key_store.sv
hw/rtl/aes_rtu_datapath.sv
hw/rtl/aes_round_transform_unit.sv
hw/rtl/aes_rtu_checker.sv
tb/tb_top.sv
